### rtl/qsse_pkg.sv
// ----------------------------------------------------------------------------
// qsse_pkg
// Types, register indexes and helpers shared by the quadrature sub-step
// speed estimator modules.
// ----------------------------------------------------------------------------
package qsse_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_US_CLOCKS     = 3'd0;
    localparam logic [2:0] CFG_IDLE_STOP     = 3'd1;
    localparam logic [2:0] CFG_PHASE_ONE     = 3'd2;
    localparam logic [2:0] CFG_PHASE_TWO     = 3'd3;
    localparam logic [2:0] CFG_PHASE_THREE   = 3'd4;
    localparam logic [2:0] CFG_REVERSE       = 3'd5;

    // reset values of the configuration registers
    localparam logic [9:0] US_CLOCKS_RST     = 10'd125;
    localparam logic [7:0] IDLE_STOP_RST     = 8'd3;
    localparam logic [7:0] PHASE_ONE_RST     = 8'd64;
    localparam logic [7:0] PHASE_TWO_RST     = 8'd128;
    localparam logic [7:0] PHASE_THREE_RST   = 8'd192;

    // fixed numbers of the estimator
    localparam logic [31:0] LOOP_CLOCKS      = 32'd13;
    localparam logic [31:0] PRIME_OFFSET     = 32'd32;
    localparam logic [31:0] SIGN_BIT         = 32'h8000_0000;
    localparam logic [31:0] STEP_MASK        = 32'hFFFF_FF00;
    localparam logic [16:0] US_PER_SEC_SCALE = 17'd62500;
    localparam int          SPEED_SHIFT      = 16;
    localparam int          SUBSTEP_SHIFT    = 20;
    localparam logic [7:0]  IDLE_MAX         = 8'd255;

    // divider operand selection
    localparam logic [1:0] DIV_TIME = 2'd0;
    localparam logic [1:0] DIV_FINE = 2'd1;
    localparam logic [1:0] DIV_HI   = 2'd2;
    localparam logic [1:0] DIV_LO   = 2'd3;

    typedef struct packed {
        logic [31:0] step_count;
        logic [31:0] cycles_word;
        logic [31:0] sample_us;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] speed;
        logic               stopped;
    } out_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic       capture;
        logic       loop_calc;
        logic       div_start;
        logic [1:0] div_sel;
        logic       t_latch;
        logic       prime;
        logic       update;
        logic       fine_latch;
        logic       trans_apply;
        logic       hi_latch;
        logic       lo_latch;
        logic       clamp;
        logic       mul;
        logic       pos;
        logic       pos_clamp;
        logic       finish;
        logic       out_load;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
        logic primed;
        logic changed;
        logic stopped;
        logic out_free;
    } status_t;

    // sub-step where a step begins
    function automatic logic [31:0] step_start(input logic [31:0] step,
                                               input logic [7:0] p1,
                                               input logic [7:0] p2,
                                               input logic [7:0] p3);
        logic [7:0] off;
        begin
            case (step[1:0])
                2'd1: off = p1;
                2'd2: off = p2;
                2'd3: off = p3;
                default: off = 8'd0;
            endcase
            step_start = ({step[25:0], 6'd0} & STEP_MASK) | {24'd0, off};
        end
    endfunction

endpackage

### rtl/quadrature_substep_speed_estimator.sv
// Each sample runs the time division; the first sample then primes the state.
// A stopped sample skips the slope divisions; tracking adds the two boundary-slope
// divisions, and a step change while moving also the fine-slope division. All
// divisions share one divider. A stalled output holds the result until it is free.
// The input stalls until the result is loaded, so one sample is taken at a time.
// Reset (rst_n, asynchronous) restores register defaults and the unprimed state.
// ----------------------------------------------------------------------------
// quadrature_substep_speed_estimator
// Estimates position and speed in sub-steps from quadrature decoder samples.
// ----------------------------------------------------------------------------
module quadrature_substep_speed_estimator
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  qsse_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output qsse_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    qsse_pkg::cmd_t    cmd;
    qsse_pkg::status_t status;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    qsse_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    qsse_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

### rtl/qsse_divider.sv
// ----------------------------------------------------------------------------
// qsse_divider
// Restoring unsigned divider, 64-bit dividend by 32-bit divisor, one
// quotient bit per cycle. A zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
module qsse_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] dvd_reg;
    logic [31:0] rem_reg;
    logic [31:0] dsr_reg;
    logic [32:0] rem_sh;
    logic        ge;
    logic [32:0] rem_sub;

    // one restoring step
    always_comb
    begin
        rem_sh  = {rem_reg, dvd_reg[63]};
        ge      = rem_sh >= {1'b0, dsr_reg};
        rem_sub = rem_sh - {1'b0, dsr_reg};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd63;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // operands
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= 32'd0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[62:0], ge};
            rem_reg <= ge ? rem_sub[31:0] : rem_sh[31:0];
        end
    end

    assign done     = done_reg;
    assign quotient = (dsr_reg == 32'd0) ? 64'd0 : dvd_reg;

endmodule

### rtl/qsse_ctrl.sv
// ----------------------------------------------------------------------------
// qsse_ctrl
// Sequencer of the estimator: walks one sample through the time division,
// state update or priming, up to three slope divisions, clamps and the result transfer.
// ----------------------------------------------------------------------------
module qsse_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  qsse_pkg::status_t status,
    output qsse_pkg::cmd_t    cmd
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_LOOP  = 5'd1;
    localparam logic [4:0] S_TDIV  = 5'd2;
    localparam logic [4:0] S_TWAIT = 5'd3;
    localparam logic [4:0] S_PRIME = 5'd4;
    localparam logic [4:0] S_UPD   = 5'd5;
    localparam logic [4:0] S_CHK   = 5'd6;
    localparam logic [4:0] S_FDIV  = 5'd7;
    localparam logic [4:0] S_FWAIT = 5'd8;
    localparam logic [4:0] S_TRANS = 5'd9;
    localparam logic [4:0] S_RUN   = 5'd10;
    localparam logic [4:0] S_HDIV  = 5'd11;
    localparam logic [4:0] S_HWAIT = 5'd12;
    localparam logic [4:0] S_LDIV  = 5'd13;
    localparam logic [4:0] S_LWAIT = 5'd14;
    localparam logic [4:0] S_CLAMP = 5'd15;
    localparam logic [4:0] S_MUL   = 5'd16;
    localparam logic [4:0] S_POS   = 5'd17;
    localparam logic [4:0] S_PCLP  = 5'd18;
    localparam logic [4:0] S_FIN   = 5'd19;
    localparam logic [4:0] S_OUT   = 5'd20;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOOP;
                end
            end
            S_LOOP:
            begin
                cmd.loop_calc = 1'b1;
                state_next    = S_TDIV;
            end
            S_TDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = qsse_pkg::DIV_TIME;
                state_next    = S_TWAIT;
            end
            S_TWAIT:
            begin
                if (status.div_done)
                begin
                    cmd.t_latch = 1'b1;
                    state_next  = status.primed ? S_UPD : S_PRIME;
                end
            end
            S_PRIME:
            begin
                cmd.prime  = 1'b1;
                state_next = S_OUT;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (status.changed && !status.stopped)
                    state_next = S_FDIV;
                else if (status.changed)
                    state_next = S_TRANS;
                else
                    state_next = S_RUN;
            end
            S_FDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = qsse_pkg::DIV_FINE;
                state_next    = S_FWAIT;
            end
            S_FWAIT:
            begin
                if (status.div_done)
                begin
                    cmd.fine_latch = 1'b1;
                    state_next     = S_TRANS;
                end
            end
            S_TRANS:
            begin
                cmd.trans_apply = 1'b1;
                state_next      = S_RUN;
            end
            S_RUN:
            begin
                state_next = status.stopped ? S_FIN : S_HDIV;
            end
            S_HDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = qsse_pkg::DIV_HI;
                state_next    = S_HWAIT;
            end
            S_HWAIT:
            begin
                if (status.div_done)
                begin
                    cmd.hi_latch = 1'b1;
                    state_next   = S_LDIV;
                end
            end
            S_LDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = qsse_pkg::DIV_LO;
                state_next    = S_LWAIT;
            end
            S_LWAIT:
            begin
                if (status.div_done)
                begin
                    cmd.lo_latch = 1'b1;
                    state_next   = S_CLAMP;
                end
            end
            S_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_POS;
            end
            S_POS:
            begin
                cmd.pos    = 1'b1;
                state_next = S_PCLP;
            end
            S_PCLP:
            begin
                cmd.pos_clamp = 1'b1;
                state_next    = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

### rtl/qsse_datapath.sv
// ----------------------------------------------------------------------------
// qsse_datapath
// Estimator state, configuration registers, shared divider, multipliers,
// clamps and the output register.
// ----------------------------------------------------------------------------
module qsse_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  qsse_pkg::in_item_t  in_data,
    input  logic                cfg_valid,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output logic                out_valid,
    input  logic                out_stall,
    output qsse_pkg::out_item_t out_data,
    input  qsse_pkg::cmd_t      cmd,
    output qsse_pkg::status_t   status
);

    localparam int SUBSTEP_SHIFT_HI = qsse_pkg::SUBSTEP_SHIFT + 31;
    localparam int SPEED_SHIFT_HI   = qsse_pkg::SPEED_SHIFT + 31;

    // configuration
    logic [9:0] us_clocks_reg;
    logic [7:0] idle_stop_reg;
    logic [7:0] phase_one_reg;
    logic [7:0] phase_two_reg;
    logic [7:0] phase_three_reg;
    logic       reverse_reg;

    // sample
    logic [31:0] step_reg;
    logic [31:0] word_reg;
    logic [31:0] now_reg;
    logic [31:0] loops_reg;
    logic [31:0] t_us_reg;

    // estimator state
    logic        primed_reg;
    logic [31:0] prev_step_reg;
    logic [31:0] last_sample_reg;
    logic [31:0] ltu_reg;
    logic [31:0] ltp_reg;
    logic [31:0] llb_reg;
    logic [31:0] lhb_reg;
    logic [31:0] fine_reg;
    logic [31:0] sps_reg;
    logic [31:0] pos_reg;
    logic        stopped_reg;
    logic [7:0]  idle_reg;
    logic        changed_reg;

    // working values
    logic [31:0] hi_reg;
    logic [31:0] lo_reg;
    logic        neg_reg;
    logic signed [63:0] prod_speed_reg;
    logic signed [63:0] prod_pos_reg;

    // output register
    logic                out_valid_reg;
    qsse_pkg::out_item_t out_reg;

    logic [31:0] low;
    logic [31:0] high;
    logic [31:0] tpos;
    logic [31:0] loops_raw;
    logic [31:0] dpos;
    logic [31:0] dus;
    logic [31:0] dpos_mag;
    logic [31:0] dus_mag;
    logic [63:0] div_dividend;
    logic [31:0] div_divisor;
    logic        div_done;
    logic [63:0] div_quot;
    logic [31:0] slope_val;
    logic        back_branch;
    logic [7:0]  idle_next;
    logic        stop_now;
    logic signed [31:0] fs_clamped;
    logic [31:0] dt_pos;
    logic [31:0] pos_sum;
    logic [31:0] pos_hi_diff;
    logic [31:0] pos_lo_diff;
    logic        out_free;

    // step bounds and transition point
    always_comb
    begin
        low  = qsse_pkg::step_start(step_reg, phase_one_reg, phase_two_reg, phase_three_reg);
        high = qsse_pkg::step_start(step_reg + 32'd1, phase_one_reg, phase_two_reg,
                                    phase_three_reg);
        tpos = word_reg[31] ? low : high;
    end

    // loop count of the transition word (multiplied by the loop length on loop_calc)
    always_comb
    begin
        if (word_reg[31])
            loops_raw = 32'd0 - word_reg;
        else
            loops_raw = qsse_pkg::SIGN_BIT - word_reg;
    end

    // prefer the previous step when the last transition is late in the interval
    assign back_branch = (ltu_reg > last_sample_reg)
                      && ($signed(ltu_reg - last_sample_reg) > $signed(now_reg - ltu_reg));

    // divider operand selection
    always_comb
    begin
        case (cmd.div_sel)
            qsse_pkg::DIV_FINE:
            begin
                dpos = tpos - ltp_reg;
                dus  = t_us_reg - ltu_reg;
            end
            qsse_pkg::DIV_HI:
            begin
                dpos = back_branch ? (ltp_reg - llb_reg) : (high - ltp_reg);
                dus  = back_branch ? (ltu_reg - last_sample_reg) : (now_reg - ltu_reg);
            end
            qsse_pkg::DIV_LO:
            begin
                dpos = back_branch ? (ltp_reg - lhb_reg) : (low - ltp_reg);
                dus  = back_branch ? (ltu_reg - last_sample_reg) : (now_reg - ltu_reg);
            end
            default:
            begin
                dpos = 32'd0;
                dus  = 32'd0;
            end
        endcase
        dpos_mag = dpos[31] ? (32'd0 - dpos) : dpos;
        dus_mag  = dus[31] ? (32'd0 - dus) : dus;
        if (cmd.div_sel == qsse_pkg::DIV_TIME)
        begin
            div_dividend = {32'd0, loops_reg};
            div_divisor  = {22'd0, us_clocks_reg};
        end
        else
        begin
            div_dividend = {12'd0, dpos_mag, 20'd0};
            div_divisor  = dus_mag;
        end
    end

    qsse_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // signed slope from the unsigned quotient
    assign slope_val = neg_reg ? (32'd0 - div_quot[31:0]) : div_quot[31:0];

    // idle counting and stop detection
    always_comb
    begin
        if (step_reg == prev_step_reg)
            idle_next = (idle_reg < qsse_pkg::IDLE_MAX) ? (idle_reg + 8'd1) : idle_reg;
        else
            idle_next = 8'd0;
        stop_now = !stopped_reg && (idle_next >= idle_stop_reg);
    end

    // speed clamp between the boundary slopes
    always_comb
    begin
        fs_clamped = $signed(fine_reg);
        if (fs_clamped > $signed(hi_reg))
            fs_clamped = $signed(hi_reg);
        if (fs_clamped < $signed(lo_reg))
            fs_clamped = $signed(lo_reg);
    end

    // position extrapolation and its bounds
    always_comb
    begin
        dt_pos      = now_reg - t_us_reg;
        pos_sum     = ltp_reg + prod_pos_reg[SUBSTEP_SHIFT_HI:qsse_pkg::SUBSTEP_SHIFT];
        pos_hi_diff = pos_reg - high;
        pos_lo_diff = pos_reg - low;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            us_clocks_reg     <= qsse_pkg::US_CLOCKS_RST;
            idle_stop_reg     <= qsse_pkg::IDLE_STOP_RST;
            phase_one_reg     <= qsse_pkg::PHASE_ONE_RST;
            phase_two_reg     <= qsse_pkg::PHASE_TWO_RST;
            phase_three_reg   <= qsse_pkg::PHASE_THREE_RST;
            reverse_reg       <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                qsse_pkg::CFG_US_CLOCKS:     us_clocks_reg     <= cfg_data[9:0];
                qsse_pkg::CFG_IDLE_STOP:     idle_stop_reg     <= cfg_data[7:0];
                qsse_pkg::CFG_PHASE_ONE:     phase_one_reg     <= cfg_data[7:0];
                qsse_pkg::CFG_PHASE_TWO:     phase_two_reg     <= cfg_data[7:0];
                qsse_pkg::CFG_PHASE_THREE:   phase_three_reg   <= cfg_data[7:0];
                qsse_pkg::CFG_REVERSE:       reverse_reg       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // sample capture and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            step_reg <= in_data.step_count;
            word_reg <= in_data.cycles_word;
            now_reg  <= in_data.sample_us;
        end
        if (cmd.loop_calc)
            loops_reg <= loops_raw * qsse_pkg::LOOP_CLOCKS;
        if (cmd.div_start)
            neg_reg <= dpos[31] ^ dus[31];
        if (cmd.t_latch)
            t_us_reg <= now_reg - div_quot[31:0];
        if (cmd.hi_latch)
            hi_reg <= slope_val;
        if (cmd.lo_latch)
            lo_reg <= slope_val;
        if (cmd.mul)
        begin
            prod_speed_reg <= 64'($signed(fine_reg) * $signed({15'd0, qsse_pkg::US_PER_SEC_SCALE}));
            prod_pos_reg   <= 64'($signed(fine_reg) * $signed({1'b0, dt_pos}));
        end
    end

    // estimator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg      <= 1'b0;
            prev_step_reg   <= 32'd0;
            last_sample_reg <= 32'd0;
            ltu_reg         <= 32'd0;
            ltp_reg         <= 32'd0;
            llb_reg         <= 32'd0;
            lhb_reg         <= 32'd0;
            fine_reg        <= 32'd0;
            sps_reg         <= 32'd0;
            pos_reg         <= 32'd0;
            stopped_reg     <= 1'b1;
            idle_reg        <= 8'd0;
            changed_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.prime)
            begin
                primed_reg      <= 1'b1;
                prev_step_reg   <= step_reg;
                last_sample_reg <= now_reg;
                ltu_reg         <= t_us_reg;
                pos_reg         <= low + qsse_pkg::PRIME_OFFSET;
            end
            if (cmd.update)
            begin
                idle_reg    <= idle_next;
                changed_reg <= (step_reg != prev_step_reg);
                if (stop_now)
                begin
                    sps_reg     <= 32'd0;
                    fine_reg    <= 32'd0;
                    stopped_reg <= 1'b1;
                end
            end
            if (cmd.fine_latch)
                fine_reg <= slope_val;
            if (cmd.trans_apply)
            begin
                stopped_reg <= 1'b0;
                ltp_reg     <= tpos;
                ltu_reg     <= t_us_reg;
            end
            if (cmd.clamp)
                fine_reg <= fs_clamped;
            if (cmd.pos)
            begin
                sps_reg <= prod_speed_reg[SPEED_SHIFT_HI:qsse_pkg::SPEED_SHIFT];
                pos_reg <= pos_sum;
            end
            if (cmd.pos_clamp)
            begin
                if ($signed(pos_hi_diff) > 0)
                    pos_reg <= high;
                else if ($signed(pos_lo_diff) < 0)
                    pos_reg <= low;
            end
            if (cmd.finish)
            begin
                llb_reg         <= low;
                lhb_reg         <= high;
                prev_step_reg   <= step_reg;
                last_sample_reg <= now_reg;
            end
        end
    end

    // output register
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.position <= reverse_reg ? $signed(32'd0 - pos_reg) : $signed(pos_reg);
            out_reg.speed    <= reverse_reg ? $signed(32'd0 - sps_reg) : $signed(sps_reg);
            out_reg.stopped  <= stopped_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // status to the sequencer
    always_comb
    begin
        status.div_done = div_done;
        status.primed   = primed_reg;
        status.changed  = changed_reg;
        status.stopped  = stopped_reg;
        status.out_free = out_free;
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives quadrature samples into the speed estimator and checks position,
// speed and stopped flag of every transfer against a cycle-free prediction.
// ----------------------------------------------------------------------------

// predicts results and keeps the queue of expected outputs
class estimate_board;
    // register copies
    bit [9:0]  us_clocks;
    bit [7:0]  idle_stop;
    bit [7:0]  ph1, ph2, ph3;
    bit        reverse;
    // estimator state
    bit        primed;
    bit [31:0] prev_step, last_sample, last_trans_us, last_trans_pos;
    bit [31:0] last_low, last_high, fine, speed_sec, pos_est;
    bit        stopped;
    bit [7:0]  idle_cnt;
    qsse_pkg::out_item_t pending[$];
    int        errors;
    int        checked;

    function void clear();
        us_clocks = 125; idle_stop = 3; ph1 = 64; ph2 = 128; ph3 = 192;
        reverse = 0; primed = 0; prev_step = 0; last_sample = 0;
        last_trans_us = 0; last_trans_pos = 0; last_low = 0; last_high = 0;
        fine = 0; speed_sec = 0; pos_est = 0; stopped = 1; idle_cnt = 0;
        pending.delete(); errors = 0; checked = 0;
    endfunction

    function void write_reg(bit [2:0] idx, bit [31:0] val);
        case (idx)
            qsse_pkg::CFG_US_CLOCKS:     us_clocks = val[9:0];
            qsse_pkg::CFG_IDLE_STOP:     idle_stop = val[7:0];
            qsse_pkg::CFG_PHASE_ONE:     ph1 = val[7:0];
            qsse_pkg::CFG_PHASE_TWO:     ph2 = val[7:0];
            qsse_pkg::CFG_PHASE_THREE:   ph3 = val[7:0];
            qsse_pkg::CFG_REVERSE:       reverse = val[0];
            default: ;
        endcase
    endfunction

    function bit [31:0] bound_of(bit [31:0] s);
        bit [7:0] off;
        case (s[1:0])
            2'd1: off = ph1;
            2'd2: off = ph2;
            2'd3: off = ph3;
            default: off = 0;
        endcase
        return ((s << 6) & 32'hFFFF_FF00) | {24'd0, off};
    endfunction

    function longint sext(bit [31:0] x);
        return longint'($signed(x));
    endfunction

    function longint fshift(longint v, int n);
        return v >>> n;
    endfunction

    function bit [31:0] slope(bit [31:0] dpos, bit [31:0] dus);
        longint den, num;
        den = sext(dus);
        num = sext(dpos) * 1048576;
        if (den == 0)
            return 0;
        return 32'(num / den);
    endfunction

    // note an accepted sample and queue the expected result
    function void note_sample(qsse_pkg::in_item_t it);
        bit [31:0] loops, t_us, lo, hi, tpos, dt;
        bit fwd;
        longint hs, ls, fs, p;
        qsse_pkg::out_item_t r;
        if (it.cycles_word[31]) begin
            loops = 0 - it.cycles_word; fwd = 1;
        end else begin
            loops = 32'h8000_0000 - it.cycles_word; fwd = 0;
        end
        loops = loops * 13;
        t_us = (us_clocks == 0) ? it.sample_us : it.sample_us - loops / us_clocks;
        if (!primed) begin
            primed = 1;
            prev_step = it.step_count;
            last_sample = it.sample_us;
            last_trans_us = t_us;
            pos_est = bound_of(it.step_count) + 32;
        end else begin
            lo = bound_of(it.step_count);
            hi = bound_of(it.step_count + 1);
            if (it.step_count == prev_step) begin
                if (idle_cnt < 255)
                    idle_cnt++;
            end else
                idle_cnt = 0;
            if (!stopped && idle_cnt >= idle_stop) begin
                speed_sec = 0; fine = 0; stopped = 1;
            end
            if (it.step_count != prev_step) begin
                tpos = fwd ? lo : hi;
                if (!stopped)
                    fine = slope(tpos - last_trans_pos, t_us - last_trans_us);
                stopped = 0;
                last_trans_pos = tpos;
                last_trans_us = t_us;
            end
            if (!stopped) begin
                if (last_trans_us > last_sample &&
                    sext(last_trans_us - last_sample) > sext(it.sample_us - last_trans_us)) begin
                    dt = last_trans_us - last_sample;
                    hs = sext(slope(last_trans_pos - last_low, dt));
                    ls = sext(slope(last_trans_pos - last_high, dt));
                end else begin
                    dt = it.sample_us - last_trans_us;
                    hs = sext(slope(hi - last_trans_pos, dt));
                    ls = sext(slope(lo - last_trans_pos, dt));
                end
                fs = sext(fine);
                if (fs > hs) fs = hs;
                if (fs < ls) fs = ls;
                fine = 32'(fs);
                speed_sec = 32'(fshift(fs * 62500, 16));
                p = fshift(fs * longint'({32'd0, it.sample_us - t_us}), 20);
                pos_est = last_trans_pos + 32'(p);
                if (sext(pos_est - hi) > 0)
                    pos_est = hi;
                else if (sext(pos_est - lo) < 0)
                    pos_est = lo;
            end
            last_low = lo;
            last_high = hi;
            prev_step = it.step_count;
            last_sample = it.sample_us;
        end
        r.position = reverse ? 0 - pos_est : pos_est;
        r.speed = reverse ? 0 - speed_sec : speed_sec;
        r.stopped = stopped;
        pending.push_back(r);
    endfunction

    task report(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, checked);
    endtask

    // compare one output transfer against the oldest expectation
    task check_result(qsse_pkg::out_item_t got);
        qsse_pkg::out_item_t w;
        if (pending.size() == 0) begin
            report("unexpected result", 0, 0);
            return;
        end
        w = pending.pop_front();
        if (got.position !== w.position) report("position", got.position, w.position);
        if (got.speed !== w.speed) report("speed", got.speed, w.speed);
        if (got.stopped !== w.stopped) report("stopped", got.stopped, w.stopped);
        checked++;
    endtask
endclass

module testbench;

    logic      clk = 0;
    logic      rst_n = 0;
    logic      in_valid = 0;
    logic      in_stall;
    qsse_pkg::in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1;
    qsse_pkg::out_item_t out_data;
    logic      cfg_valid = 0;
    logic      cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    estimate_board board = new();
    bit   calm_period = 0;
    bit   hold_off = 0;
    bit   done = 0;
    int   sent = 0;
    // running motion used for well-formed samples
    bit [31:0] cur_step, cur_us;

    quadrature_substep_speed_estimator dut (.*);

    always #5 clk = ~clk;

    // output side: random stalls, long hold-off on request
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_data);
        if (!rst_n)
            out_stall <= 1;
        else
            out_stall <= hold_off || (!calm_period && $urandom_range(99) < 30);
    end

    task automatic write_cfg(input logic [2:0] idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        board.write_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic send_sample(input qsse_pkg::in_item_t it);
        while (!calm_period && $urandom_range(99) < 30) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_data <= it;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_sample(it);
        sent++;
        in_valid <= 0;
        @(posedge clk);
    endtask

    // wait until every result has arrived or a limit runs out, then let the block settle
    task automatic drain();
        int n;
        n = 0;
        while (board.pending.size() != 0 && n < 200000) begin
            @(posedge clk);
            n++;
        end
        repeat (300) @(posedge clk);
    endtask

    // sample of a plausible motion: small step moves, mostly consistent timing
    function automatic qsse_pkg::in_item_t motion_sample();
        qsse_pkg::in_item_t it;
        int mv;
        bit [31:0] loops;
        mv = $urandom_range(6);
        cur_us += $urandom_range(2000, 1);
        if (mv == 1) cur_step += 1;
        else if (mv == 2) cur_step -= 1;
        else if (mv == 3) cur_step += $urandom_range(3, 2);
        loops = $urandom_range(20000);
        it.step_count = cur_step;
        it.sample_us = cur_us;
        it.cycles_word = (mv == 2) ? 32'h8000_0000 - loops : 0 - loops;
        if (mv == 4) it.cycles_word = $urandom;
        return it;
    endfunction

    function automatic qsse_pkg::in_item_t noise_sample();
        qsse_pkg::in_item_t it;
        it.step_count = $urandom;
        it.cycles_word = $urandom;
        it.sample_us = $urandom;
        return it;
    endfunction

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
            send_sample(($urandom_range(9) < 8) ? motion_sample() : noise_sample());
    endtask

    initial begin
        qsse_pkg::in_item_t it;
        board.clear();
        cur_step = $urandom;
        cur_us = $urandom;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: priming, extremes of the fields, both directions
        it = '{32'd0, 32'h8000_0000, 32'd0};                  send_sample(it);
        it = '{32'd0, 32'h8000_0000, 32'd0};                  send_sample(it);
        it = '{32'd1, 32'hFFFF_FFFF, 32'd100};                send_sample(it);
        it = '{32'd2, 32'hFFFF_FF00, 32'd200};                send_sample(it);
        it = '{32'd1, 32'h7FFF_FF00, 32'd300};                send_sample(it);
        it = '{32'd1, 32'h7FFF_FF00, 32'd300};                send_sample(it);
        it = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};  send_sample(it);
        it = '{32'd0, 32'h7FFF_FFFF, 32'd5};                  send_sample(it);
        it = '{32'd0, 32'h0000_0001, 32'd5};                  send_sample(it);
        it = '{32'd0, 32'h8000_0001, 32'd9};                  send_sample(it);
        it = '{32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000};  send_sample(it);
        it = '{32'h8000_0003, 32'hFFFF_FFFE, 32'h8000_0010};  send_sample(it);
        for (int i = 0; i < 5; i++) send_sample(motion_sample());
        drain();

        // extreme register settings
        write_cfg(qsse_pkg::CFG_US_CLOCKS, 32'd0);
        write_cfg(qsse_pkg::CFG_IDLE_STOP, 32'd1);
        write_cfg(qsse_pkg::CFG_PHASE_ONE, 32'd0);
        write_cfg(qsse_pkg::CFG_PHASE_TWO, 32'd255);
        write_cfg(qsse_pkg::CFG_PHASE_THREE, 32'hFFFF_FF00);
        write_cfg(qsse_pkg::CFG_REVERSE, 32'd1);
        random_phase(120);
        drain();

        write_cfg(qsse_pkg::CFG_US_CLOCKS, 32'hFFFF_FFFF);
        write_cfg(qsse_pkg::CFG_IDLE_STOP, 32'd255);
        write_cfg(qsse_pkg::CFG_PHASE_ONE, 32'd255);
        write_cfg(qsse_pkg::CFG_PHASE_TWO, 32'd0);
        write_cfg(qsse_pkg::CFG_PHASE_THREE, 32'd255);
        write_cfg(qsse_pkg::CFG_REVERSE, 32'd0);
        random_phase(150);
        drain();

        // long calm stretch, then a receiver hold-off while the sender pushes
        calm_period = 1;
        write_cfg(qsse_pkg::CFG_US_CLOCKS, 32'd1);
        write_cfg(qsse_pkg::CFG_IDLE_STOP, 32'd4);
        random_phase(150);
        hold_off = 1;
        fork
            begin
                repeat (3000) @(posedge clk);
                hold_off = 0;
            end
            random_phase(20);
        join
        calm_period = 0;
        drain();

        write_cfg(qsse_pkg::CFG_US_CLOCKS, 32'd125);
        write_cfg(qsse_pkg::CFG_IDLE_STOP, 32'd3);
        write_cfg(qsse_pkg::CFG_PHASE_ONE, 32'd64);
        write_cfg(qsse_pkg::CFG_PHASE_TWO, 32'd128);
        write_cfg(qsse_pkg::CFG_PHASE_THREE, 32'd192);
        write_cfg(qsse_pkg::CFG_REVERSE, 32'd1);
        random_phase(300);
        drain();

        write_cfg(qsse_pkg::CFG_US_CLOCKS, $urandom_range(1000, 1));
        write_cfg(qsse_pkg::CFG_REVERSE, 32'd0);
        random_phase(250);
        drain();

        $display("covered %0d samples with %0d results over six register settings,",
                 sent, board.checked);
        $display("including priming, stop detection, noise and a long output hold-off");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASS quadrature_substep_speed_estimator");
        else
            $display("FAIL quadrature_substep_speed_estimator");
        $finish;
    end

    // overall time limit
    initial begin
        #20ms;
        $display("FAIL quadrature_substep_speed_estimator");
        $finish;
    end
endmodule
